### rtl/bea_pkg.sv
// ----------------------------------------------------------------------------
// bea_pkg
// Shared types and constants for the bitmap extent allocator.
// ----------------------------------------------------------------------------
package bea_pkg;

  localparam int unsigned POS_W   = 13;
  localparam int unsigned START_W = 12;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e             cmd;
    logic             fill_val;
    logic [POS_W-1:0] goal;
    logic [POS_W-1:0] minl;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] count;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] hint;
  } req_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic             found;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] len;
  } res_t;

endpackage

### rtl/bea_ram.sv
// ----------------------------------------------------------------------------
// bea_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bea_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/bea_seq.sv
// ----------------------------------------------------------------------------
// bea_seq
// Bit-serial map sequencer: next-fit scan, range fill and clearing sweep.
// ----------------------------------------------------------------------------
module bea_seq
  import bea_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  req_t                          req_i,
  input  logic                          ack_i,
  output res_t                          res_o,
  output logic                          ram_we_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] ram_addr_o,
  output logic                          ram_wdata_o,
  input  logic                          ram_rdata_i
);

  localparam int unsigned AW = $clog2(MAX_BLOCKS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_FILL  = 7'b0000100,
    S_STEP  = 7'b0001000,
    S_EVAL  = 7'b0010000,
    S_PICK  = 7'b0100000,
    S_DONE  = 7'b1000000
  } seq_state_e;

  seq_state_e       state_q, state_d;
  req_t             req_q, req_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] run_start_q, run_start_d;
  logic [POS_W-1:0] run_len_q, run_len_d;
  logic [POS_W-1:0] best_start_q, best_start_d;
  logic [POS_W-1:0] best_len_q, best_len_d;
  logic             wrapped_q, wrapped_d;
  logic             in_run_q, in_run_d;
  logic [POS_W-1:0] fill_ptr_q, fill_ptr_d;
  logic [POS_W-1:0] fill_end_q, fill_end_d;
  logic             fill_val_q, fill_val_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] ext_start_q, ext_start_d;
  logic [POS_W-1:0] ext_len_q, ext_len_d;
  logic             end_run;
  logic             win;
  logic [POS_W-1:0] win_start;
  logic [POS_W-1:0] win_len;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    pos_d        = pos_q;
    run_start_d  = run_start_q;
    run_len_d    = run_len_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    wrapped_d    = wrapped_q;
    in_run_d     = in_run_q;
    fill_ptr_d   = fill_ptr_q;
    fill_end_d   = fill_end_q;
    fill_val_d   = fill_val_q;
    clr_d        = clr_q;
    found_d      = found_q;
    ext_start_d  = ext_start_q;
    ext_len_d    = ext_len_q;
    ram_we_o     = 1'b0;
    ram_addr_o   = AW'(pos_q);
    ram_wdata_o  = 1'b0;
    end_run      = 1'b0;
    win          = 1'b0;
    win_start    = pos_q;
    win_len      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d        = req_i;
          found_d      = 1'b0;
          ext_start_d  = '0;
          ext_len_d    = '0;
          pos_d        = req_i.hint;
          wrapped_d    = 1'b0;
          in_run_d     = 1'b0;
          best_len_d   = '0;
          best_start_d = '0;
          run_len_d    = '0;
          unique case (req_i.cmd)
            CMD_ALLOC: state_d = S_STEP;
            CMD_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLEAR;
            end
            CMD_FILL: begin
              fill_ptr_d = req_i.first;
              fill_end_d = req_i.first + req_i.count;
              fill_val_d = req_i.fill_val;
              state_d    = (req_i.count != '0) ? S_FILL : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        ram_we_o   = 1'b1;
        ram_addr_o = clr_q;
        clr_d      = clr_q + 1'b1;
        if (32'(clr_q) == MAX_BLOCKS - 1) begin
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        ram_we_o    = 1'b1;
        ram_addr_o  = AW'(fill_ptr_q);
        ram_wdata_o = fill_val_q;
        fill_ptr_d  = fill_ptr_q + 1'b1;
        if (fill_ptr_d == fill_end_q) begin
          state_d = S_DONE;
        end
      end
      S_STEP: begin
        if (!in_run_q) begin
          if (pos_q >= req_q.total) begin
            if (wrapped_q) begin
              state_d = S_PICK;
            end else begin
              wrapped_d = 1'b1;
              pos_d     = '0;
            end
          end else begin
            state_d = S_EVAL;
          end
        end else if (pos_q < req_q.total && run_len_q < req_q.goal) begin
          state_d = S_EVAL;
        end else begin
          end_run = 1'b1;
        end
      end
      S_EVAL: begin
        if (!in_run_q) begin
          if (ram_rdata_i) begin
            pos_d   = pos_q + 1'b1;
            state_d = S_STEP;
          end else if (req_q.goal == '0) begin
            win = 1'b1;
          end else begin
            run_start_d = pos_q;
            run_len_d   = POS_W'(1);
            pos_d       = pos_q + 1'b1;
            in_run_d    = 1'b1;
            state_d     = S_STEP;
          end
        end else if (!ram_rdata_i) begin
          pos_d     = pos_q + 1'b1;
          run_len_d = run_len_q + 1'b1;
          state_d   = S_STEP;
        end else begin
          end_run = 1'b1;
        end
      end
      S_PICK: begin
        if (best_len_q != '0) begin
          win       = 1'b1;
          win_start = best_start_q;
          win_len   = best_len_q;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (end_run) begin
      in_run_d = 1'b0;
      if (run_len_q >= req_q.goal) begin
        win       = 1'b1;
        win_start = run_start_q;
        win_len   = req_q.goal;
      end else begin
        if (run_len_q > best_len_q && run_len_q >= req_q.minl) begin
          best_start_d = run_start_q;
          best_len_d   = run_len_q;
        end
        state_d = (wrapped_q && pos_q >= req_q.hint) ? S_PICK : S_STEP;
      end
    end

    if (win) begin
      found_d     = 1'b1;
      ext_start_d = win_start;
      ext_len_d   = win_len;
      fill_ptr_d  = win_start;
      fill_end_d  = win_start + win_len;
      fill_val_d  = 1'b1;
      state_d     = (win_len != '0) ? S_FILL : S_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pos_q        <= pos_d;
    run_start_q  <= run_start_d;
    run_len_q    <= run_len_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    wrapped_q    <= wrapped_d;
    in_run_q     <= in_run_d;
    fill_ptr_q   <= fill_ptr_d;
    fill_end_q   <= fill_end_d;
    fill_val_q   <= fill_val_d;
    ext_start_q  <= ext_start_d;
    ext_len_q    <= ext_len_d;
  end

  assign res_o.idle  = (state_q == S_IDLE);
  assign res_o.done  = (state_q == S_DONE);
  assign res_o.found = found_q;
  assign res_o.start = ext_start_q;
  assign res_o.len   = ext_len_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |-> fill_ptr_q < fill_end_q)
    else $error("fill pointer past range end");

  a_eval_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EVAL |-> pos_q < req_q.total)
    else $error("scan read beyond map end");

  a_extent_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && found_q && req_q.cmd == CMD_ALLOC)
      |-> (14'(ext_start_q) + 14'(ext_len_q)) <= 14'(req_q.total))
    else $error("extent exceeds map");

endmodule

### rtl/bitmap_extent_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_extent_allocator
// Next-fit bitmap extent allocator with free count and hint.
// ----------------------------------------------------------------------------
// The map sits in a one-bit-wide single-port RAM and one sequencer walks it a
// bit at a time. After reset, and on every init transaction, the map is
// cleared block by block, during which no transaction is accepted. An
// allocate visits each block it scans with a read step and then an evaluate
// step, walking the map at most twice, and then marks each block of the extent.
// Free and reserve write each clipped block in turn.
// One transaction is worked on at a time; a finished result may wait on the
// output while the next transaction is accepted.
module bitmap_extent_allocator
  import bea_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [POS_W-1:0]   blocks_in_use_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [POS_W-1:0]   goal_length_i,
  input  logic [POS_W-1:0]   min_length_i,
  input  logic [START_W-1:0] range_start_i,
  input  logic [POS_W-1:0]   range_length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic [START_W-1:0] extent_start_o,
  output logic [POS_W-1:0]   extent_length_o,
  output logic [POS_W-1:0]   free_count_o
);

  localparam int unsigned AW        = $clog2(MAX_BLOCKS);
  localparam int unsigned TOTAL_CAP = (MAX_BLOCKS > 8191) ? 8191 : MAX_BLOCKS;

  logic [POS_W-1:0]   biu_q;
  logic [POS_W-1:0]   free_q, free_d;
  logic [POS_W-1:0]   hint_q, hint_d;
  logic               busy_q;
  op_e                op_q;
  logic [POS_W-1:0]   n_q;
  logic               out_valid_q;
  logic               status_q;
  logic [START_W-1:0] ext_start_q;
  logic [POS_W-1:0]   ext_len_q;
  logic [POS_W-1:0]   free_out_q;

  logic [POS_W-1:0]   total;
  logic [POS_W-1:0]   rs_ext;
  logic [POS_W-1:0]   clip_n;
  logic               in_fire;
  logic               ack;
  logic               finish;
  req_t               req;
  res_t               res;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic               ram_wdata;
  logic               ram_rdata;
  logic [POS_W:0]     free_sum;

  assign total = (biu_q > POS_W'(TOTAL_CAP)) ? POS_W'(TOTAL_CAP) : biu_q;
  assign rs_ext = POS_W'(range_start_i);
  assign clip_n = (rs_ext >= total) ? '0 :
                  (range_length_i > total - rs_ext) ? total - rs_ext : range_length_i;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_q && res.idle;
  assign in_fire     = in_valid_i && in_ready_o;
  assign ack         = res.done && (!busy_q || !out_valid_q || out_ready_i);
  assign finish      = busy_q && ack;

  always_comb begin
    req          = '0;
    req.goal     = goal_length_i;
    req.minl     = min_length_i;
    req.first    = rs_ext;
    req.count    = clip_n;
    req.total    = total;
    req.hint     = (hint_q >= total) ? '0 : hint_q;
    req.fill_val = 1'b0;
    unique case (op_e'(operation_i))
      OP_ALLOC:   req.cmd = (free_q >= min_length_i) ? CMD_ALLOC : CMD_NONE;
      OP_FREE:    req.cmd = CMD_FILL;
      OP_RESERVE: begin
        req.cmd      = CMD_FILL;
        req.fill_val = 1'b1;
      end
      OP_INIT:    req.cmd = CMD_CLEAR;
      default:    req.cmd = CMD_NONE;
    endcase
  end

  assign free_sum = {1'b0, free_q} + {1'b0, n_q};

  always_comb begin
    free_d = free_q;
    hint_d = hint_q;
    unique case (op_q)
      OP_ALLOC: begin
        if (res.found) begin
          free_d = (free_q > res.len) ? free_q - res.len : '0;
          hint_d = res.start + res.len;
        end
      end
      OP_FREE:    free_d = (free_sum > {1'b0, total}) ? total : free_sum[POS_W-1:0];
      OP_RESERVE: free_d = (free_q > n_q) ? free_q - n_q : '0;
      OP_INIT: begin
        free_d = total;
        hint_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q       <= POS_W'(4096);
      free_q      <= POS_W'(4096);
      hint_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        biu_q <= blocks_in_use_i;
      end
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (finish) begin
        busy_q <= 1'b0;
      end
      if (finish) begin
        free_q      <= free_d;
        hint_q      <= hint_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= op_e'(operation_i);
      n_q  <= clip_n;
    end
    if (finish) begin
      status_q    <= (op_q == OP_ALLOC) && !res.found;
      ext_start_q <= (op_q == OP_ALLOC) ? res.start[START_W-1:0] : '0;
      ext_len_q   <= (op_q == OP_ALLOC) ? res.len : '0;
      free_out_q  <= free_d;
    end
  end

  bea_seq #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .req_i      (req),
    .ack_i      (ack),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .ram_rdata_i(ram_rdata)
  );

  bea_ram #(
    .WIDTH(1),
    .DEPTH(MAX_BLOCKS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign extent_start_o  = ext_start_q;
  assign extent_length_o = ext_len_q;
  assign free_count_o    = free_out_q;

endmodule
